[rtl/core/gsa_pkg.sv]
// Shared types and constants for the generational slot allocator.
// No dependencies; used by every module under rtl/core.
package gsa_pkg;

    localparam int SLOTS  = 1024;
    localparam int SLOT_W = 10;
    localparam int FILL_W = 11;
    localparam int GEN_W  = 16;
    localparam int CNT_W  = 16;

    localparam logic [15:0] MIN_LIMIT   = 16'd256;
    localparam logic [15:0] LIMIT_RESET = 16'd256;

    localparam logic [2:0] OP_ALLOC    = 3'd0;
    localparam logic [2:0] OP_DESTROY  = 3'd1;
    localparam logic [2:0] OP_VALIDATE = 3'd2;
    localparam logic [2:0] OP_SPAWN    = 3'd3;
    localparam logic [2:0] OP_KILL     = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_STALE   = 2'd2;
    localparam logic [1:0] ST_LIMIT   = 2'd3;

    typedef struct packed {
        logic [2:0]        operation;
        logic [SLOT_W-1:0] slot_index;
        logic [GEN_W-1:0]  handle_generation;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] result_slot;
        logic [GEN_W-1:0]  result_generation;
        logic [CNT_W-1:0]  slot_alive;
        logic [CNT_W-1:0]  total_alive;
    } rsp_t;

    typedef struct packed {
        logic             active;
        logic             destroyed;
        logic [GEN_W-1:0] generation;
        logic [CNT_W-1:0] alive;
    } slot_entry_t;

    typedef struct packed {
        logic              rd_en;
        logic              pop;
        logic              push;
        logic [SLOT_W-1:0] push_slot;
    } stack_ctl_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        slot_entry_t       wr_data;
    } table_ctl_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_POP,
        FSM_EXEC
    } fsm_t;

    function automatic logic [GEN_W-1:0] gen_bump(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] n;
        n = g + GEN_W'(1);
        if (n == '0) begin
            n = GEN_W'(1);
        end
        return n;
    endfunction

endpackage

[rtl/core/gsa_slot_table.sv]
// Slot table: one synchronous RAM entry per slot (flags, generation, count).
// Depends on gsa_pkg.
module gsa_slot_table (
    input  logic                  aclk,
    input  gsa_pkg::table_ctl_t   ctl,
    output gsa_pkg::slot_entry_t  rd_data
);

    gsa_pkg::slot_entry_t slot_mem [gsa_pkg::SLOTS];
    gsa_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            slot_mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= slot_mem[ctl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/gsa_free_stack.sv]
// LIFO of freed slot indexes in a synchronous RAM, with its fill depth.
// Depends on gsa_pkg.
module gsa_free_stack (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  gsa_pkg::stack_ctl_t          ctl,
    output logic [gsa_pkg::SLOT_W-1:0]   top_slot,
    output logic [gsa_pkg::FILL_W-1:0]   depth
);

    logic [gsa_pkg::SLOT_W-1:0] stack_mem [gsa_pkg::SLOTS];
    logic [gsa_pkg::SLOT_W-1:0] top_slot_reg;
    logic [gsa_pkg::FILL_W-1:0] depth_reg;
    logic [gsa_pkg::FILL_W-1:0] depth_next;
    logic [gsa_pkg::FILL_W-1:0] depth_m1;
    logic                       not_full;

    assign depth_m1 = depth_reg - gsa_pkg::FILL_W'(1);
    assign not_full = depth_reg < gsa_pkg::FILL_W'(gsa_pkg::SLOTS);

    always_comb begin
        depth_next = depth_reg;
        if (ctl.pop) begin
            depth_next = depth_m1;
        end else if (ctl.push && not_full) begin
            depth_next = depth_reg + gsa_pkg::FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push && not_full) begin
            stack_mem[depth_reg[gsa_pkg::SLOT_W-1:0]] <= ctl.push_slot;
        end
        if (ctl.rd_en) begin
            top_slot_reg <= stack_mem[depth_m1[gsa_pkg::SLOT_W-1:0]];
        end
    end

    assign top_slot = top_slot_reg;
    assign depth    = depth_reg;

endmodule

[rtl/core/generational_slot_allocator.sv]
// Top level: request sequencer and read-modify-write datapath of the slot map.
// Depends on gsa_pkg, gsa_slot_table and gsa_free_stack.
//
//  port group   dir  handshake            payload
//  s_           in   s_valid / s_ready    gsa_pkg::req_t
//  m_           out  m_valid / m_ready    gsa_pkg::rsp_t
//  cfg_         in   cfg_valid / cfg_ready  max_particles, 16 bit
//
// Alloc from the free stack runs through stack read, slot read and update; a
// fresh or failing alloc goes straight to update; other requests do slot read, update.
// One request is in flight; a new one is taken while a response waits in m_data.
// The update cycle holds while the output register is full and not taken.
// Reset is synchronous; the used_reg count marks which entries are valid, so the
// RAMs need no clearing pass and the block is ready right after reset.
module generational_slot_allocator (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  gsa_pkg::req_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output gsa_pkg::rsp_t  m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [15:0]    cfg_data
);

    gsa_pkg::fsm_t state_reg, state_next;
    gsa_pkg::req_t req_reg, req_next;
    logic [gsa_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic fresh_reg, fresh_next;
    logic popped_reg, popped_next;
    logic fail_reg, fail_next;
    logic [gsa_pkg::FILL_W-1:0] used_reg, used_next;
    logic [gsa_pkg::CNT_W-1:0]  live_reg, live_next;
    logic [15:0]                max_reg;
    logic                       m_valid_reg, m_valid_next;
    gsa_pkg::rsp_t              m_data_reg, m_data_next;

    gsa_pkg::table_ctl_t   tbl_ctl;
    gsa_pkg::slot_entry_t  tbl_rd;
    gsa_pkg::stack_ctl_t   stk_ctl;
    logic [gsa_pkg::SLOT_W-1:0] stk_top;
    logic [gsa_pkg::FILL_W-1:0] stk_depth;

    gsa_pkg::slot_entry_t ent, ne;
    logic        in_range, handle_ok, do_write, do_release, out_free;
    logic [1:0]  status;
    logic [gsa_pkg::CNT_W-1:0] live_new, cnt_dec, limit;

    gsa_slot_table u_table (
        .aclk    (aclk),
        .ctl     (tbl_ctl),
        .rd_data (tbl_rd)
    );

    gsa_free_stack u_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (stk_ctl),
        .top_slot (stk_top),
        .depth    (stk_depth)
    );

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign limit     = (max_reg < gsa_pkg::MIN_LIMIT) ? gsa_pkg::MIN_LIMIT : max_reg;
    assign in_range  = {1'b0, idx_reg} < used_reg;
    assign ent       = in_range ? tbl_rd : '0;
    assign handle_ok = in_range && ent.active && !ent.destroyed &&
                       (ent.generation == req_reg.handle_generation);
    assign cnt_dec   = (ent.alive != '0) ? ent.alive - gsa_pkg::CNT_W'(1) : '0;

    // update of the addressed entry
    always_comb begin
        ne         = ent;
        do_write   = 1'b0;
        do_release = 1'b0;
        status     = gsa_pkg::ST_DONE;
        live_new   = live_reg;
        case (req_reg.operation)
            gsa_pkg::OP_ALLOC: begin
                if (fail_reg) begin
                    status = gsa_pkg::ST_NO_SLOT;
                end else begin
                    ne.active    = 1'b1;
                    ne.destroyed = 1'b0;
                    ne.alive     = '0;
                    if (ent.generation == '0) begin
                        ne.generation = gsa_pkg::GEN_W'(1);
                    end
                    do_write = 1'b1;
                end
            end
            gsa_pkg::OP_DESTROY: begin
                if (handle_ok) begin
                    ne.destroyed = 1'b1;
                    do_write     = 1'b1;
                    do_release   = (ent.alive == '0);
                end else begin
                    status = gsa_pkg::ST_STALE;
                end
            end
            gsa_pkg::OP_VALIDATE: begin
                if (!handle_ok) begin
                    status = gsa_pkg::ST_STALE;
                end
            end
            gsa_pkg::OP_SPAWN: begin
                if (!in_range || !ent.active) begin
                    status = gsa_pkg::ST_STALE;
                end else if (live_reg >= limit) begin
                    status = gsa_pkg::ST_LIMIT;
                end else begin
                    live_new = live_reg + gsa_pkg::CNT_W'(1);
                    ne.alive = ent.alive + gsa_pkg::CNT_W'(1);
                    do_write = 1'b1;
                end
            end
            gsa_pkg::OP_KILL: begin
                if (in_range && ent.active) begin
                    ne.alive   = cnt_dec;
                    do_write   = 1'b1;
                    do_release = ent.destroyed && (cnt_dec == '0);
                end
                if (live_reg != '0) begin
                    live_new = live_reg - gsa_pkg::CNT_W'(1);
                end
            end
            default: begin
                status = gsa_pkg::ST_STALE;
            end
        endcase
        if (do_release) begin
            ne.active     = 1'b0;
            ne.destroyed  = 1'b0;
            ne.alive      = '0;
            ne.generation = gsa_pkg::gen_bump(ent.generation);
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        idx_next     = idx_reg;
        fresh_next   = fresh_reg;
        popped_next  = popped_reg;
        fail_next    = fail_reg;
        used_next    = used_reg;
        live_next    = live_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;
        tbl_ctl      = '0;
        stk_ctl      = '0;
        case (state_reg)
            gsa_pkg::FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next    = s_data;
                    idx_next    = s_data.slot_index;
                    fresh_next  = 1'b0;
                    popped_next = 1'b0;
                    fail_next   = 1'b0;
                    state_next  = gsa_pkg::FSM_EXEC;
                    if (s_data.operation == gsa_pkg::OP_ALLOC) begin
                        if (stk_depth != '0) begin
                            stk_ctl.rd_en = 1'b1;
                            popped_next   = 1'b1;
                            state_next    = gsa_pkg::FSM_POP;
                        end else if (used_reg < gsa_pkg::FILL_W'(gsa_pkg::SLOTS)) begin
                            idx_next   = used_reg[gsa_pkg::SLOT_W-1:0];
                            fresh_next = 1'b1;
                        end else begin
                            fail_next = 1'b1;
                        end
                    end else begin
                        tbl_ctl.rd_en   = 1'b1;
                        tbl_ctl.rd_addr = s_data.slot_index;
                    end
                end
            end
            gsa_pkg::FSM_POP: begin
                tbl_ctl.rd_en   = 1'b1;
                tbl_ctl.rd_addr = stk_top;
                idx_next        = stk_top;
                state_next      = gsa_pkg::FSM_EXEC;
            end
            gsa_pkg::FSM_EXEC: begin
                if (out_free) begin
                    tbl_ctl.wr_en     = do_write;
                    tbl_ctl.wr_addr   = idx_reg;
                    tbl_ctl.wr_data   = ne;
                    stk_ctl.pop       = popped_reg;
                    stk_ctl.push      = do_release;
                    stk_ctl.push_slot = idx_reg;
                    if (fresh_reg) begin
                        used_next = used_reg + gsa_pkg::FILL_W'(1);
                    end
                    live_next    = live_new;
                    m_valid_next = 1'b1;
                    if (fail_reg) begin
                        m_data_next = '{status: status, result_slot: '0,
                                        result_generation: '0, slot_alive: '0,
                                        total_alive: live_new};
                    end else if (in_range || fresh_reg) begin
                        m_data_next = '{status: status, result_slot: idx_reg,
                                        result_generation: ne.generation,
                                        slot_alive: ne.alive, total_alive: live_new};
                    end else begin
                        m_data_next = '{status: status, result_slot: idx_reg,
                                        result_generation: '0, slot_alive: '0,
                                        total_alive: live_new};
                    end
                    state_next = gsa_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = gsa_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gsa_pkg::FSM_IDLE;
            used_reg    <= '0;
            live_reg    <= '0;
            max_reg     <= gsa_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
            fresh_reg   <= 1'b0;
            popped_reg  <= 1'b0;
            fail_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
            fresh_reg   <= fresh_next;
            popped_reg  <= popped_next;
            fail_reg    <= fail_next;
            if (cfg_valid && cfg_ready) begin
                max_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // freed slots are always a subset of used slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        stk_depth <= used_reg)
        else $error("free stack deeper than used slot count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= gsa_pkg::FILL_W'(gsa_pkg::SLOTS))
        else $error("used slot count beyond table size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.operation != gsa_pkg::OP_ALLOC))
        |=> (state_reg == gsa_pkg::FSM_EXEC))
        else $error("slot request did not go to update");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gsa_pkg::FSM_EXEC && m_valid && !m_ready)
        |=> (state_reg == gsa_pkg::FSM_EXEC) && $stable(live_reg))
        else $error("update committed into a full output register");

endmodule
